// ----- rtl/tabt_pkg.sv -----
`timescale 1ns / 1ps

package tabt_pkg;

  localparam int TABLE_ENTRIES = 5;
  localparam int TIME_BITS     = 32;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int ADDR_W        = 64;
  localparam int NOW_W         = 32;
  localparam int SECS_W        = 16;
  localparam int TICKS_W       = 11;
  localparam int PROD_W        = SECS_W + TICKS_W;
  localparam int SLOT_W        = 3;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 16;

  localparam logic [TICKS_W-1:0] TICKS_RESET  = TICKS_W'(128);
  localparam logic [SECS_W-1:0]  THRESH_RESET = SECS_W'(65000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TICKS_PER_SECOND    = 1'b0,
    REG_PERMANENT_THRESHOLD = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_TEMP_SET      = 2'd0,
    ST_PERM_SET      = 2'd1,
    ST_ALREADY_PERM  = 2'd2,
    ST_TABLE_FULL    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SCAN   = 2'd1,
    S_FINISH = 2'd2
  } state_t;

  typedef struct packed {
    logic              op;
    logic [ADDR_W-1:0] addr_high;
    logic [ADDR_W-1:0] addr_low;
    logic [SECS_W-1:0] block_seconds;
    logic [NOW_W-1:0]  now;
  } in_t;

  typedef struct packed {
    logic              is_dropped;
    status_t           status;
    logic [SLOT_W-1:0] slot;
  } out_t;

endpackage

// ----- rtl/timed_address_block_table.sv -----
`timescale 1ns / 1ps
// channel   dir  handshake             payload
// in        in   in_valid / in_stall   in_data  (op, addr_high, addr_low, block_seconds, now)
// out       out  out_valid / out_stall out_data (is_dropped, status, slot)
// cfg       in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// each item is taken in idle, then scanned one table entry at a time through the shared
// 128-bit address comparator, then resolved, and the table is updated
// reset clears the used/active/permanent flags and loads the register defaults
// a new item is taken while a result waits on out_stall; the resolve step holds
// until the output register is free
module timed_address_block_table (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  tabt_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output tabt_pkg::out_t                  out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tabt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tabt_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tabt_pkg::*;

  state_t state_r, state_nxt;

  logic [TICKS_W-1:0] tps_r;
  logic [SECS_W-1:0]  thresh_r;

  logic [TABLE_ENTRIES-1:0] used_r;
  logic [TABLE_ENTRIES-1:0] active_r;
  logic [TABLE_ENTRIES-1:0] forever_r;
  logic [ADDR_W-1:0]        addr_hi_r [TABLE_ENTRIES];
  logic [ADDR_W-1:0]        addr_lo_r [TABLE_ENTRIES];
  logic [TIME_BITS-1:0]     dline_r   [TABLE_ENTRIES];

  in_t                  item_r;
  logic [IDX_W-1:0]     idx_r;
  logic                 match_r;
  logic [IDX_W-1:0]     match_idx_r;
  logic                 free_r;
  logic [IDX_W-1:0]     free_idx_r;
  logic [TIME_BITS-1:0] hit_dl_r;
  logic [PROD_W-1:0]    prod_r;

  logic out_valid_r;
  out_t out_data_r;

  logic in_acc, scan_en, fin_go, scan_last, cmp_hit;

  // finish step decisions
  out_t                 res;
  logic                 wr_en;
  logic                 clr_active;
  logic [IDX_W-1:0]     tgt_idx;
  logic                 set_forever;
  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] dl_new;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;
  assign scan_last = (idx_r == IDX_W'(TABLE_ENTRIES - 1));
  assign cmp_hit   = used_r[idx_r] && (addr_hi_r[idx_r] == item_r.addr_high)
                     && (addr_lo_r[idx_r] == item_r.addr_low);
  assign now_t     = TIME_BITS'(item_r.now);
  assign dl_new    = now_t + TIME_BITS'(prod_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_acc) state_nxt = S_SCAN;
      S_SCAN:   if (scan_last) state_nxt = S_FINISH;
      S_FINISH: if (fin_go) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    scan_en  = 1'b0;
    fin_go   = 1'b0;
    unique case (state_r)
      S_IDLE:   in_stall = 1'b0;
      S_SCAN:   scan_en = 1'b1;
      S_FINISH: fin_go = !out_valid_r || !out_stall;
      default:  in_stall = 1'b1;
    endcase
  end

  always_comb begin
    res         = '0;
    wr_en       = 1'b0;
    clr_active  = 1'b0;
    tgt_idx     = match_r ? match_idx_r : free_idx_r;
    set_forever = (item_r.block_seconds >= thresh_r);
    if (!item_r.op) begin
      if (match_r) begin
        if (forever_r[match_idx_r]) begin
          res.is_dropped = 1'b1;
        end else if (active_r[match_idx_r]) begin
          // deadline passed: lift the block
          if (now_t > hit_dl_r) begin
            clr_active = 1'b1;
          end else begin
            res.is_dropped = 1'b1;
          end
        end
      end
    end else if (!match_r && !free_r) begin
      res.status = ST_TABLE_FULL;
    end else begin
      res.slot = SLOT_W'(tgt_idx);
      if (match_r && forever_r[tgt_idx]) begin
        res.status = ST_ALREADY_PERM;
      end else begin
        wr_en      = 1'b1;
        res.status = set_forever ? ST_PERM_SET : ST_TEMP_SET;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      tps_r     <= TICKS_RESET;
      thresh_r  <= THRESH_RESET;
      used_r    <= '0;
      active_r  <= '0;
      forever_r <= '0;
      out_valid_r <= 1'b0;
      idx_r     <= '0;
      match_r   <= 1'b0;
      free_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_TICKS_PER_SECOND:    tps_r    <= cfg_data[TICKS_W-1:0];
          REG_PERMANENT_THRESHOLD: thresh_r <= cfg_data[SECS_W-1:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        idx_r   <= '0;
        match_r <= 1'b0;
        free_r  <= 1'b0;
      end else if (scan_en) begin
        if (!scan_last) idx_r <= idx_r + IDX_W'(1);
        if (cmp_hit && !match_r) match_r <= 1'b1;
        if (!used_r[idx_r] && !free_r) free_r <= 1'b1;
      end
      if (fin_go) begin
        if (clr_active) active_r[match_idx_r] <= 1'b0;
        if (wr_en) begin
          used_r[tgt_idx]   <= 1'b1;
          active_r[tgt_idx] <= 1'b1;
          forever_r[tgt_idx] <= set_forever;
        end
      end
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) item_r <= in_data;
    if (scan_en) begin
      prod_r <= PROD_W'(item_r.block_seconds) * PROD_W'(tps_r);
      if (cmp_hit && !match_r) begin
        match_idx_r <= idx_r;
        hit_dl_r    <= dline_r[idx_r];
      end
      if (!used_r[idx_r] && !free_r) free_idx_r <= idx_r;
    end
    if (fin_go && wr_en) begin
      addr_hi_r[tgt_idx] <= item_r.addr_high;
      addr_lo_r[tgt_idx] <= item_r.addr_low;
      dline_r[tgt_idx]   <= dl_new;
    end
    if (fin_go) out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_flags_need_used: assert property (@(posedge clk) disable iff (!rst_n)
    ((active_r | forever_r) & ~used_r) == '0)
    else $error("active or permanent flag on an unused entry");

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_SCAN) && (idx_r == '0))
    else $error("accepted item did not start a scan");

  a_finish_after_full_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH) |-> scan_last)
    else $error("resolve step reached before the scan covered every entry");

  a_finish_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    fin_go |=> out_valid_r && (state_r == S_IDLE))
    else $error("resolve step did not load the output register");

endmodule

// ----- tb/sv/tabt_tb_pkg.sv -----
`timescale 1ns / 1ps

package tabt_tb_pkg;

  // op field of an input transfer
  localparam logic OP_CHECK = 1'b0;
  localparam logic OP_BLOCK = 1'b1;

endpackage

// ----- tb/sv/timed_address_block_table_checker.sv -----
`timescale 1ns / 1ps

module timed_address_block_table_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  tabt_pkg::in_t                   in_data,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  tabt_pkg::out_t                  out_data,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [tabt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tabt_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              pending,
  output int                              compared
);
  import tabt_pkg::*;
  import tabt_tb_pkg::*;

  logic [TICKS_W-1:0] ticks_cfg;
  logic [SECS_W-1:0]  thresh_cfg;

  logic              tbl_used     [TABLE_ENTRIES];
  logic              tbl_active   [TABLE_ENTRIES];
  logic              tbl_forever  [TABLE_ENTRIES];
  logic [ADDR_W-1:0] tbl_hi       [TABLE_ENTRIES];
  logic [ADDR_W-1:0] tbl_lo       [TABLE_ENTRIES];
  logic [NOW_W-1:0]  tbl_deadline [TABLE_ENTRIES];

  out_t verdict_q[$];
  out_t want;
  int   errs = 0;
  int   n_compared = 0;

  // verdict for one item, updating the table as the block does
  function automatic out_t apply_item(in_t it);
    out_t r;
    int   hit;
    int   free_idx;
    r        = '0;
    r.status = ST_TEMP_SET;
    hit      = -1;
    free_idx = -1;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (hit < 0 && tbl_used[i] && tbl_hi[i] == it.addr_high && tbl_lo[i] == it.addr_low)
        hit = i;
    end
    if (it.op == OP_CHECK) begin
      if (hit >= 0) begin
        if (tbl_forever[hit]) begin
          r.is_dropped = 1'b1;
        end else if (tbl_active[hit]) begin
          // deadline passed: the block lapses and the source goes through
          if (it.now > tbl_deadline[hit]) tbl_active[hit] = 1'b0;
          else r.is_dropped = 1'b1;
        end
      end
    end else begin
      if (hit < 0) begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (free_idx < 0 && !tbl_used[i]) free_idx = i;
        end
        if (free_idx >= 0) begin
          hit                 = free_idx;
          tbl_used[hit]       = 1'b1;
          tbl_active[hit]     = 1'b0;
          tbl_forever[hit]    = 1'b0;
          tbl_hi[hit]         = it.addr_high;
          tbl_lo[hit]         = it.addr_low;
        end
      end
      if (hit < 0) begin
        r.status = ST_TABLE_FULL;
      end else begin
        r.slot = SLOT_W'(hit);
        if (tbl_forever[hit]) begin
          r.status = ST_ALREADY_PERM;
        end else begin
          tbl_active[hit]   = 1'b1;
          tbl_deadline[hit] = it.now + NOW_W'(it.block_seconds) * NOW_W'(ticks_cfg);
          if (it.block_seconds >= thresh_cfg) begin
            tbl_forever[hit] = 1'b1;
            r.status         = ST_PERM_SET;
          end
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      ticks_cfg  = TICKS_RESET;
      thresh_cfg = THRESH_RESET;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        tbl_used[i]     = 1'b0;
        tbl_active[i]   = 1'b0;
        tbl_forever[i]  = 1'b0;
        tbl_hi[i]       = '0;
        tbl_lo[i]       = '0;
        tbl_deadline[i] = '0;
      end
      verdict_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TICKS_PER_SECOND:    ticks_cfg  = cfg_data[TICKS_W-1:0];
          REG_PERMANENT_THRESHOLD: thresh_cfg = cfg_data[SECS_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) verdict_q.push_back(apply_item(in_data));
      if (out_valid && !out_stall) begin
        n_compared++;
        if (verdict_q.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("unexpected result transfer: dropped=%0d status=%0d slot=%0d",
                     out_data.is_dropped, out_data.status, out_data.slot);
        end else begin
          want = verdict_q.pop_front();
          if (out_data.is_dropped !== want.is_dropped || out_data.status !== want.status ||
              out_data.slot !== want.slot) begin
            errs++;
            if (errs <= 10)
              $display("mismatch: expected dropped/status/slot %0d/%0d/%0d, got %0d/%0d/%0d",
                       want.is_dropped, want.status, want.slot,
                       out_data.is_dropped, out_data.status, out_data.slot);
          end
        end
      end
    end
    pending    <= verdict_q.size();
    fail_count <= errs;
    compared   <= n_compared;
  end

endmodule

// ----- tb/sv/timed_address_block_table_tb.sv -----
`timescale 1ns / 1ps

module timed_address_block_table_tb;
  import tabt_pkg::*;
  import tabt_tb_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 400;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_t                   in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int fail_count;
  int pending;
  int compared;

  logic no_idle = 1'b0;
  logic burst_req = 1'b0;
  logic burst_done = 1'b0;
  int   hold_left = 0;
  int   cycle_count = 0;
  int   items_sent = 0;
  int   directed_items = 0;
  int   settings_used = 1;

  logic [ADDR_W-1:0] known_hi [TABLE_ENTRIES];
  logic [ADDR_W-1:0] known_lo [TABLE_ENTRIES];
  logic [NOW_W-1:0]  tick_now = 32'd1000;

  timed_address_block_table DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  timed_address_block_table_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .compared(compared)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (burst_req && !burst_done) begin
      burst_done <= 1'b1;
      hold_left  <= LONG_HOLD;
      out_stall  <= 1'b1;
    end else begin
      out_stall <= !no_idle && ($urandom_range(0, 99) < 30);
    end
  end

  task automatic send(input logic op, input logic [ADDR_W-1:0] hi, input logic [ADDR_W-1:0] lo,
                      input logic [SECS_W-1:0] secs, input logic [NOW_W-1:0] now_val);
    in_t item;
    item.op            = op;
    item.addr_high     = hi;
    item.addr_low      = lo;
    item.block_seconds = secs;
    item.now           = now_val;
    if (!no_idle && $urandom_range(0, 99) < 30) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // the checker's count is registered, so it lags behind the transfer
  task automatic drain();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_regs(input logic [CFG_DATA_W-1:0] ticks_word,
                            input logic [CFG_DATA_W-1:0] thr_word);
    cfg_valid <= 1'b1;
    cfg_index <= REG_TICKS_PER_SECOND;
    cfg_data  <= ticks_word;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_PERMANENT_THRESHOLD;
    cfg_data  <= thr_word;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] ticks_word,
                           input logic [CFG_DATA_W-1:0] thr_word,
                           input int count, input logic quiet, input logic with_burst);
    int                pick;
    int                k;
    int                bitn;
    int                step;
    logic [ADDR_W-1:0] hi;
    logic [ADDR_W-1:0] lo;
    logic [SECS_W-1:0] secs;
    logic              op;
    drain();
    write_regs(ticks_word, thr_word);
    no_idle <= quiet;
    step = int'(ticks_word[TICKS_W-1:0]) * 6 + 3;
    for (int n = 0; n < count; n++) begin
      if (with_burst && n == 20) burst_req <= 1'b1;
      pick = $urandom_range(0, 99);
      k    = $urandom_range(0, TABLE_ENTRIES - 1);
      hi   = known_hi[k];
      lo   = known_lo[k];
      if (pick >= 85) begin
        hi = {$urandom, $urandom};
        lo = {$urandom, $urandom};
      end else if (pick >= 70) begin
        // one bit off a stored address
        bitn = $urandom_range(0, 127);
        if (bitn < 64) hi[bitn] = ~hi[bitn];
        else lo[bitn - 64] = ~lo[bitn - 64];
      end
      op   = ($urandom_range(0, 99) < 45) ? OP_BLOCK : OP_CHECK;
      secs = ($urandom_range(0, 4) == 0) ? SECS_W'($urandom) : SECS_W'($urandom_range(0, 40));
      pick = $urandom_range(0, 99);
      if (pick < 3) tick_now = $urandom;
      else if (pick < 5) tick_now = 32'hFFFF_FFFF - $urandom_range(0, 2000);
      else tick_now = tick_now + $urandom_range(0, step);
      send(op, hi, lo, secs, (pick >= 95) ? NOW_W'($urandom) : tick_now);
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    known_hi[0] = '0;                      known_lo[0] = '0;
    known_hi[1] = '1;                      known_lo[1] = '1;
    known_hi[2] = 64'h0123_4567_89AB_CDEF; known_lo[2] = 64'hFEDC_BA98_7654_3210;
    known_hi[3] = 64'h8000_0000_0000_0001; known_lo[3] = 64'h7FFF_FFFF_FFFF_FFFE;
    known_hi[4] = {$urandom, $urandom};    known_lo[4] = {$urandom, $urandom};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset register values: 128 ticks per second, threshold 65000
    send(OP_CHECK, known_hi[0], known_lo[0], 16'd0, 32'd0);
    send(OP_BLOCK, known_hi[0], known_lo[0], 16'd0, 32'd100);
    send(OP_CHECK, known_hi[0], known_lo[0], 16'hFFFF, 32'd100);
    send(OP_CHECK, known_hi[0], known_lo[0], 16'd0, 32'd101);
    send(OP_CHECK, known_hi[0], known_lo[0], 16'd0, 32'd101);
    send(OP_BLOCK, known_hi[1], known_lo[1], 16'hFFFF, 32'hFFFF_FFFF);
    send(OP_BLOCK, known_hi[1], known_lo[1], 16'd1, 32'd0);
    send(OP_CHECK, known_hi[1], known_lo[1], 16'd0, 32'hFFFF_FFFF);
    send(OP_BLOCK, known_hi[2], known_lo[2], 16'd64999, 32'd5);
    send(OP_BLOCK, known_hi[3], known_lo[3], 16'd65000, 32'd5);
    // deadline wraps past the top of the time range
    send(OP_BLOCK, known_hi[4], known_lo[4], 16'd10, 32'hFFFF_FF00);
    send(OP_CHECK, known_hi[4], known_lo[4], 16'd0, 32'hFFFF_FFF0);
    send(OP_BLOCK, known_hi[4], known_lo[4], 16'd1, 32'd0);
    send(OP_CHECK, 64'h8000_0000_0000_0000, 64'd0, 16'd0, 32'd50);
    send(OP_CHECK, '1, 64'hFFFF_FFFF_FFFF_FFFE, 16'd0, 32'd50);
    send(OP_BLOCK, {$urandom, $urandom}, {$urandom, $urandom}, 16'd3, 32'd50);
    send(OP_BLOCK, known_hi[0], known_lo[0], 16'd2, 32'd200);
    send(OP_CHECK, known_hi[0], known_lo[0], 16'd0, 32'd456);
    send(OP_CHECK, known_hi[0], known_lo[0], 16'd0, 32'd457);
    send(OP_CHECK, known_hi[2], known_lo[2], 16'd0, 32'd5);
    send(OP_CHECK, known_hi[3], known_lo[3], 16'd0, 32'd0);
    in_valid <= 1'b0;
    directed_items = items_sent;

    run_phase(16'd1,     16'd65535, 150, 1'b0, 1'b1);
    run_phase(16'd0,     16'd65535, 100, 1'b0, 1'b0);
    // upper bits of the ticks word fall outside the register
    run_phase(16'hF805,  16'd65000, 150, 1'b1, 1'b0);
    run_phase(16'd1024,  16'd65535, 130, 1'b0, 1'b0);
    run_phase(16'd2047,  16'd50,     60, 1'b0, 1'b0);
    run_phase(16'd37,    16'd0,      30, 1'b0, 1'b0);

    drain();
    repeat (20) @(posedge clk);
    $display("Sent %0d items (%0d directed) under %0d register settings, %0d results compared.",
             items_sent, directed_items, settings_used, compared);
    $display("Covered expiry, wraparound, permanent blocks, table full and a long output stall.");
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
